### design/resident_id_number_checker_defines.svh
// assertion macros for the resident identity number checker
`ifndef RESIDENT_ID_NUMBER_CHECKER_DEFINES_SVH
`define RESIDENT_ID_NUMBER_CHECKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RIDC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ridc assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define RIDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ridc assertion failed");

`endif

### design/ridc_pkg.sv
// shared types, constants and helper functions of the identity number checker
package ridc_pkg;

    localparam int REGION_DEPTH = 16;
    localparam int REGION_IDX_W = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
    localparam int COUNT_W      = $clog2(REGION_DEPTH + 1);

    localparam int CMD_W        = 2;
    localparam int CODE_W       = 20;
    localparam int CHAR_W       = 8;
    localparam int YEAR_W       = 14;
    localparam int VERDICT_W    = 2;
    localparam int POS_W        = 5;
    localparam int FLD_W        = 3;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 8;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 14;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHAR   = 2'd2;

    localparam logic [VERDICT_W-1:0] VERDICT_INVALID = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_MALE    = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FEMALE  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_YEAR = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_YEAR = 1'd1;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd1900;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = 14'd2011;

    localparam logic [POS_W-1:0] LAST_POS = 5'd17;

    // which accumulator a character feeds
    localparam logic [FLD_W-1:0] FLD_REGION  = 3'd0;
    localparam logic [FLD_W-1:0] FLD_CENTURY = 3'd1;
    localparam logic [FLD_W-1:0] FLD_DECADE  = 3'd2;
    localparam logic [FLD_W-1:0] FLD_MONTH   = 3'd3;
    localparam logic [FLD_W-1:0] FLD_DAY     = 3'd4;
    localparam logic [FLD_W-1:0] FLD_SEQ     = 3'd5;
    localparam logic [FLD_W-1:0] FLD_CHECK   = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [FLD_W-1:0]  fld;
        logic [3:0]        digit;
        logic [3:0]        term;
        logic              bad;
        logic [CODE_W-1:0] code;
    } item_t;

    // 2^(17-pos) mod 11
    function automatic logic [3:0] pos_weight(input logic [POS_W-1:0] pos);
        logic [3:0] w;
        case (pos)
            5'd0:    w = 4'd7;
            5'd1:    w = 4'd9;
            5'd2:    w = 4'd10;
            5'd3:    w = 4'd5;
            5'd4:    w = 4'd8;
            5'd5:    w = 4'd4;
            5'd6:    w = 4'd2;
            5'd7:    w = 4'd1;
            5'd8:    w = 4'd6;
            5'd9:    w = 4'd3;
            5'd10:   w = 4'd7;
            5'd11:   w = 4'd9;
            5'd12:   w = 4'd10;
            5'd13:   w = 4'd5;
            5'd14:   w = 4'd8;
            5'd15:   w = 4'd4;
            5'd16:   w = 4'd2;
            5'd17:   w = 4'd1;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // doubling modulo 11 of a residue
    function automatic logic [3:0] mod11_double(input logic [3:0] x);
        logic [4:0] d;
        d = {x, 1'b0};
        if (d >= 5'd11)
        begin
            d = d - 5'd11;
        end
        return d[3:0];
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

### design/resident_id_number_checker.sv
// top level of the resident identity number checker
// Takes one beat per clock while s_tready is high: tuser carries the command (clear,
// append region code, identity character) and tdata the region code and the ASCII
// character. After the 18th character one verdict beat leaves on the master side
// (0 invalid, 1 male, 2 female). An accepted beat is held in the queue and then
// applied by the back end, which registers the verdict in its output register; the
// sustained rate is one beat per cycle when the output does not stall, set by the
// accumulator update and the parallel compare against the 16-entry region table. A
// stalled verdict holds the back end, and the two-entry queue then back-pressures the
// slave side. The user writes min_year and max_year through cfg_we/cfg_addr/cfg_data
// only while the block is idle; the block itself does not enforce this.
module resident_id_number_checker
    import ridc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CMD_W-1:0]       s_tuser,   // cmd
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // region_code[19:0], id_char[27:20], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // verdict[1:0], zero pad
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic  q_full;
    logic  q_push;
    item_t q_in;
    logic  q_pop;
    item_t q_out;
    logic  q_valid;

    ridc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    ridc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out),
        .not_empty (q_valid)
    );

    ridc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_item   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### design/ridc_front.sv
// front end: accepts beats, tracks the character position and classifies each character
module ridc_front
    import ridc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CMD_W-1:0]      s_tuser,   // cmd
    input  logic [IN_TDATA_W-1:0] s_tdata,   // region_code[19:0], id_char[27:20], zero pad
    input  logic                  q_full,
    output logic                  q_push,
    output item_t                 q_item
);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_X    = 8'h58;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [CHAR_W-1:0] id_char;
    logic [3:0]        digit;
    logic              bad;
    logic [3:0]        w1;
    logic [3:0]        w2;
    logic [3:0]        w4;
    logic [3:0]        w8;
    logic [5:0]        wsum;
    logic [3:0]        term;
    logic [FLD_W-1:0]  fld;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign id_char  = s_tdata[CODE_W +: CHAR_W];

    always_comb
    begin
        digit = 4'd0;
        bad   = 1'b0;
        if (id_char >= CHAR_ZERO && id_char <= CHAR_NINE)
        begin
            digit = 4'(id_char - CHAR_ZERO);
        end
        else if (pos_reg == LAST_POS && id_char == CHAR_X)
        begin
            digit = 4'd10;
        end
        else
        begin
            bad = 1'b1;
        end
    end

    // residue of digit times weight, summed over the digit's bits
    always_comb
    begin
        w1   = pos_weight(pos_reg);
        w2   = mod11_double(w1);
        w4   = mod11_double(w2);
        w8   = mod11_double(w4);
        wsum = (digit[0] ? 6'(w1) : 6'd0) + (digit[1] ? 6'(w2) : 6'd0)
             + (digit[2] ? 6'(w4) : 6'd0) + (digit[3] ? 6'(w8) : 6'd0);
        if (wsum >= 6'd33)
        begin
            term = 4'(wsum - 6'd33);
        end
        else if (wsum >= 6'd22)
        begin
            term = 4'(wsum - 6'd22);
        end
        else if (wsum >= 6'd11)
        begin
            term = 4'(wsum - 6'd11);
        end
        else
        begin
            term = wsum[3:0];
        end
    end

    always_comb
    begin
        if (pos_reg < 5'd6)
        begin
            fld = FLD_REGION;
        end
        else if (pos_reg < 5'd8)
        begin
            fld = FLD_CENTURY;
        end
        else if (pos_reg < 5'd10)
        begin
            fld = FLD_DECADE;
        end
        else if (pos_reg < 5'd12)
        begin
            fld = FLD_MONTH;
        end
        else if (pos_reg < 5'd14)
        begin
            fld = FLD_DAY;
        end
        else if (pos_reg < LAST_POS)
        begin
            fld = FLD_SEQ;
        end
        else
        begin
            fld = FLD_CHECK;
        end
    end

    always_comb
    begin
        q_item.cmd   = s_tuser;
        q_item.fld   = fld;
        q_item.digit = digit;
        q_item.term  = term;
        q_item.bad   = bad;
        q_item.code  = s_tdata[CODE_W-1:0];
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            case (s_tuser)
                CMD_CLEAR: pos_next = '0;
                CMD_CHAR:  pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 5'd1;
                default:   pos_next = pos_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

### design/ridc_queue.sv
// short queue between the front end and the back end
module ridc_queue
    import ridc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  not_empty
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/ridc_back.sv
// back end: region table, accumulators, verdict and output register
module ridc_back
    import ridc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   q_valid,
    input  item_t                  q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // verdict[1:0], zero pad
);

    logic [CODE_W-1:0]    table_reg [REGION_DEPTH];
    logic                 table_we;

    logic [YEAR_W-1:0]    min_year_reg;
    logic [YEAR_W-1:0]    min_year_next;
    logic [YEAR_W-1:0]    max_year_reg;
    logic [YEAR_W-1:0]    max_year_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [CODE_W-1:0]    region_acc_reg;
    logic [CODE_W-1:0]    region_acc_next;
    logic [YEAR_W-1:0]    year_acc_reg;
    logic [YEAR_W-1:0]    year_acc_next;
    logic [6:0]           century_acc_reg;
    logic [6:0]           century_acc_next;
    logic                 decade_nz_reg;
    logic                 decade_nz_next;
    logic [6:0]           month_acc_reg;
    logic [6:0]           month_acc_next;
    logic [6:0]           day_acc_reg;
    logic [6:0]           day_acc_next;
    logic [9:0]           seq_acc_reg;
    logic [9:0]           seq_acc_next;
    logic [3:0]           residue_reg;
    logic [3:0]           residue_next;
    logic                 bad_reg;
    logic                 bad_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [VERDICT_W-1:0] verdict_next;

    logic [4:0]           res_sum;
    logic [3:0]           res_fin;
    logic                 region_hit;
    logic                 leap;
    logic [4:0]           day_limit;
    logic                 date_ok;
    logic [VERDICT_W-1:0] verdict;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - VERDICT_W)'(0), verdict_reg};

    assign res_sum = 5'(residue_reg) + 5'(q_item.term);
    assign res_fin = (res_sum >= 5'd11) ? 4'(res_sum - 5'd11) : res_sum[3:0];

    always_comb
    begin
        region_hit = 1'b0;
        for (int i = 0; i < REGION_DEPTH; i++)
        begin
            if (COUNT_W'(i) < count_reg && table_reg[i] == region_acc_reg)
            begin
                region_hit = 1'b1;
            end
        end
    end

    // gregorian leap year from the binary year and the decimal digit groups
    always_comb
    begin
        leap = (year_acc_reg[1:0] == 2'd0 && decade_nz_reg)
            || (!decade_nz_reg && century_acc_reg[1:0] == 2'd0);
        day_limit = month_days(month_acc_reg[3:0])
                  + ((month_acc_reg == 7'd2 && leap) ? 5'd1 : 5'd0);
        date_ok = (month_acc_reg >= 7'd1) && (month_acc_reg <= 7'd12)
               && (day_acc_reg >= 7'd1)
               && (year_acc_reg >= min_year_reg) && (year_acc_reg <= max_year_reg)
               && (day_acc_reg <= 7'(day_limit));
        if (bad_reg || q_item.bad || !region_hit || !date_ok
            || seq_acc_reg == 10'd0 || res_fin != 4'd1)
        begin
            verdict = VERDICT_INVALID;
        end
        else
        begin
            verdict = seq_acc_reg[0] ? VERDICT_MALE : VERDICT_FEMALE;
        end
    end

    always_comb
    begin
        min_year_next    = min_year_reg;
        max_year_next    = max_year_reg;
        count_next       = count_reg;
        region_acc_next  = region_acc_reg;
        year_acc_next    = year_acc_reg;
        century_acc_next = century_acc_reg;
        decade_nz_next   = decade_nz_reg;
        month_acc_next   = month_acc_reg;
        day_acc_next     = day_acc_reg;
        seq_acc_next     = seq_acc_reg;
        residue_next     = residue_reg;
        bad_next         = bad_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        verdict_next     = verdict_reg;
        table_we         = 1'b0;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_YEAR: min_year_next = cfg_data;
                REG_MAX_YEAR: max_year_next = cfg_data;
                default:      min_year_next = min_year_reg;
            endcase
        end

        if (q_pop)
        begin
            case (q_item.cmd)
                CMD_CLEAR:
                begin
                    count_next       = '0;
                    region_acc_next  = '0;
                    year_acc_next    = '0;
                    century_acc_next = '0;
                    decade_nz_next   = 1'b0;
                    month_acc_next   = '0;
                    day_acc_next     = '0;
                    seq_acc_next     = '0;
                    residue_next     = '0;
                    bad_next         = 1'b0;
                end
                CMD_APPEND:
                begin
                    if (count_reg < COUNT_W'(REGION_DEPTH))
                    begin
                        table_we   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_CHAR:
                begin
                    residue_next = res_fin;
                    bad_next     = bad_reg || q_item.bad;
                    case (q_item.fld)
                        FLD_REGION:
                        begin
                            region_acc_next = region_acc_reg * CODE_W'(10)
                                            + CODE_W'(q_item.digit);
                        end
                        FLD_CENTURY:
                        begin
                            year_acc_next    = year_acc_reg * YEAR_W'(10)
                                             + YEAR_W'(q_item.digit);
                            century_acc_next = century_acc_reg * 7'd10 + 7'(q_item.digit);
                        end
                        FLD_DECADE:
                        begin
                            year_acc_next  = year_acc_reg * YEAR_W'(10)
                                           + YEAR_W'(q_item.digit);
                            decade_nz_next = decade_nz_reg || (q_item.digit != 4'd0);
                        end
                        FLD_MONTH:
                        begin
                            month_acc_next = month_acc_reg * 7'd10 + 7'(q_item.digit);
                        end
                        FLD_DAY:
                        begin
                            day_acc_next = day_acc_reg * 7'd10 + 7'(q_item.digit);
                        end
                        FLD_SEQ:
                        begin
                            seq_acc_next = seq_acc_reg * 10'd10 + 10'(q_item.digit);
                        end
                        FLD_CHECK:
                        begin
                            out_valid_next   = 1'b1;
                            verdict_next     = verdict;
                            region_acc_next  = '0;
                            year_acc_next    = '0;
                            century_acc_next = '0;
                            decade_nz_next   = 1'b0;
                            month_acc_next   = '0;
                            day_acc_next     = '0;
                            seq_acc_next     = '0;
                            residue_next     = '0;
                            bad_next         = 1'b0;
                        end
                        default:
                        begin
                            bad_next = bad_reg || q_item.bad;
                        end
                    endcase
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (table_we)
        begin
            table_reg[count_reg[REGION_IDX_W-1:0]] <= q_item.code;
        end
        verdict_reg <= verdict_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg    <= MIN_YEAR_RESET;
            max_year_reg    <= MAX_YEAR_RESET;
            count_reg       <= '0;
            region_acc_reg  <= '0;
            year_acc_reg    <= '0;
            century_acc_reg <= '0;
            decade_nz_reg   <= 1'b0;
            month_acc_reg   <= '0;
            day_acc_reg     <= '0;
            seq_acc_reg     <= '0;
            residue_reg     <= '0;
            bad_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            min_year_reg    <= min_year_next;
            max_year_reg    <= max_year_next;
            count_reg       <= count_next;
            region_acc_reg  <= region_acc_next;
            year_acc_reg    <= year_acc_next;
            century_acc_reg <= century_acc_next;
            decade_nz_reg   <= decade_nz_next;
            month_acc_reg   <= month_acc_next;
            day_acc_reg     <= day_acc_next;
            seq_acc_reg     <= seq_acc_next;
            residue_reg     <= residue_next;
            bad_reg         <= bad_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

### design/ridc_checker.sv
// port-level checks of the identity number checker and their binding
`include "resident_id_number_checker_defines.svh"

module ridc_port_checks
    import ridc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled verdict beat stays put
    `RIDC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // only the three verdict codes appear
    `RIDC_ASSERT_IMPL(a_verdict_code, m_tvalid, m_tdata[VERDICT_W-1:0] <= VERDICT_FEMALE)
    // padding bits stay zero
    `RIDC_ASSERT_IMPL(a_out_pad, m_tvalid, m_tdata[OUT_TDATA_W-1:VERDICT_W] == '0)
    // no verdict straight out of reset
    `RIDC_ASSERT_IMPL(a_reset_quiet, $past(!rst_n), !m_tvalid)

endmodule

bind resident_id_number_checker ridc_port_checks u_ridc_port_checks (.*);

### bench/ridc_checker.sv
// checker that predicts and compares the verdict beats of the identity number checker
`timescale 1ns / 100ps

module ridc_checker
    import ridc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [CMD_W-1:0]       s_tuser,   // cmd
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // region_code[19:0], id_char[27:20], zero pad
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // verdict[1:0], zero pad
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     waiting,
    output int                     seen_invalid,
    output int                     seen_male,
    output int                     seen_female
);

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam int unsigned       ID_LEN     = 18;

    logic [YEAR_W-1:0]    year_lo;
    logic [YEAR_W-1:0]    year_hi;
    logic [CODE_W-1:0]    region_codes [REGION_DEPTH];
    logic [COUNT_W-1:0]   region_fill;
    logic [POS_W-1:0]     char_pos;
    logic [CODE_W-1:0]    region_sum;
    logic [YEAR_W-1:0]    year_sum;
    logic [6:0]           month_sum;
    logic [6:0]           day_sum;
    logic [9:0]           serial_sum;
    logic [3:0]           residue;
    logic                 saw_bad;
    logic [VERDICT_W-1:0] verdicts_due [$];
    logic [VERDICT_W-1:0] want;
    logic [VERDICT_W-1:0] got;

    task automatic report_mismatch(input string what);
        $display("%0t ns: verdict mismatch: %s", $time, what);
        errors++;
    endtask

    // 2 to the power (17 - p), reduced mod 11
    function automatic int unsigned check_weight(input int unsigned p);
        int unsigned w;
        w = 1;
        repeat (17 - p) w = (w * 2) % 11;
        return w;
    endfunction

    task automatic forget_number();
        char_pos   = '0;
        region_sum = '0;
        year_sum   = '0;
        month_sum  = '0;
        day_sum    = '0;
        serial_sum = '0;
        residue    = '0;
        saw_bad    = 1'b0;
    endtask

    function automatic logic [VERDICT_W-1:0] judge_number();
        logic        known;
        logic        leap;
        logic        date_fine;
        int unsigned limit;
        known = 1'b0;
        for (int i = 0; i < REGION_DEPTH; i++)
        begin
            if (i < region_fill && region_codes[i] == region_sum)
            begin
                known = 1'b1;
            end
        end
        leap = ((year_sum % 4 == 0) && (year_sum % 100 != 0)) || (year_sum % 400 == 0);
        case (month_sum)
            1, 3, 5, 7, 8, 10, 12: limit = 31;
            4, 6, 9, 11:           limit = 30;
            2:                     limit = leap ? 29 : 28;
            default:               limit = 0;
        endcase
        date_fine = (month_sum >= 1) && (month_sum <= 12) && (day_sum >= 1)
                    && (day_sum <= limit) && (year_sum >= year_lo) && (year_sum <= year_hi);
        if (saw_bad || !known || !date_fine || serial_sum == 0 || residue != 1)
        begin
            return VERDICT_INVALID;
        end
        return serial_sum[0] ? VERDICT_MALE : VERDICT_FEMALE;
    endfunction

    task automatic take_char(input logic [CHAR_W-1:0] ch);
        int unsigned p;
        int unsigned v;
        p = 32'(char_pos);
        if (p >= ID_LEN)
        begin
            p = 0;
        end
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            v = 32'(ch) - 32'(CH_ZERO);
        end
        else if (p == ID_LEN - 1 && ch == CH_UPPER_X)
        begin
            v = 10;
        end
        else
        begin
            v = 0;
            saw_bad = 1'b1;
        end
        if (p < 6)
        begin
            region_sum = CODE_W'(region_sum * 10 + v);
        end
        else if (p < 10)
        begin
            year_sum = YEAR_W'(year_sum * 10 + v);
        end
        else if (p < 12)
        begin
            month_sum = 7'(month_sum * 10 + v);
        end
        else if (p < 14)
        begin
            day_sum = 7'(day_sum * 10 + v);
        end
        else if (p < 17)
        begin
            serial_sum = 10'(serial_sum * 10 + v);
        end
        residue = 4'((residue + v * check_weight(p)) % 11);
        if (p == ID_LEN - 1)
        begin
            verdicts_due = {verdicts_due, judge_number()};
            forget_number();
        end
        else
        begin
            char_pos = POS_W'(p + 1);
        end
    endtask

    task automatic apply_beat(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                              input logic [CHAR_W-1:0] ch);
        case (cmd)
            CMD_CLEAR:
            begin
                region_fill = '0;
                forget_number();
            end
            CMD_APPEND:
            begin
                if (region_fill < REGION_DEPTH)
                begin
                    region_codes[region_fill[REGION_IDX_W-1:0]] = code;
                    region_fill++;
                end
            end
            CMD_CHAR:
            begin
                take_char(ch);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            year_lo      = MIN_YEAR_RESET;
            year_hi      = MAX_YEAR_RESET;
            region_fill  = '0;
            forget_number();
            verdicts_due.delete();
            errors       = 0;
            seen_invalid = 0;
            seen_male    = 0;
            seen_female  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[VERDICT_W-1:0];
                if (verdicts_due.size() == 0)
                begin
                    report_mismatch($sformatf("verdict %0d with none predicted", got));
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (got !== want)
                    begin
                        report_mismatch($sformatf("verdict %0d, predicted %0d", got, want));
                    end
                    case (want)
                        VERDICT_MALE:   seen_male++;
                        VERDICT_FEMALE: seen_female++;
                        default:        seen_invalid++;
                    endcase
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MIN_YEAR: year_lo = cfg_data;
                    REG_MAX_YEAR: year_hi = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                apply_beat(s_tuser, s_tdata[CODE_W-1:0], s_tdata[CODE_W +: CHAR_W]);
            end
        end
        waiting = verdicts_due.size();
    end

endmodule

### bench/tb_top.sv
// top of the identity number checker testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import ridc_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_X  = 8'h78;
    localparam int                LONG_HOLD   = 400;
    localparam int                QUIET_LIMIT = 4000;
    localparam int                SETTLE      = 8;
    localparam int                PHASE_BEATS = 32;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CMD_W-1:0]       s_tuser  = '0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int chk_errors;
    int chk_waiting;
    int chk_invalid;
    int chk_male;
    int chk_female;

    bit                idle_on      = 1'b0;
    bit                hold_req     = 1'b0;
    int                stall_left   = 0;
    int                quiet_cycles = 0;
    int                beats_sent   = 0;
    int                stored_count = 0;
    int                lo_now       = 1900;
    int                hi_now       = 2011;
    int                serial;
    int                lo_pick;
    logic [CHAR_W-1:0] id_buf [18];
    int                usable [$];

    always #10 clk = ~clk;

    resident_id_number_checker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    ridc_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .errors       (chk_errors),
        .waiting      (chk_waiting),
        .seen_invalid (chk_invalid),
        .seen_male    (chk_male),
        .seen_female  (chk_female)
    );

    // output side readiness: random stall bursts and one long hold-off
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else if (hold_req)
        begin
            hold_req   = 1'b0;
            m_tready   = 1'b0;
            stall_left = LONG_HOLD - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", QUIET_LIMIT);
                $display("resident_id_number_checker verification failed");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                             input logic [CHAR_W-1:0] ch);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap      = $urandom_range(1, 16);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {4'b0000, ch, code};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (cmd != CMD_UNUSED)
        begin
            beats_sent++;
        end
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        send_beat(CMD_CHAR, CODE_W'($urandom_range(0, 20'hFFFFF)), ch);
    endtask

    task automatic send_clear();
        send_beat(CMD_CLEAR, CODE_W'($urandom_range(0, 20'hFFFFF)),
                  CHAR_W'($urandom_range(0, 255)));
        usable.delete();
        stored_count = 0;
    endtask

    task automatic send_append(input int code);
        send_beat(CMD_APPEND, CODE_W'(code), CHAR_W'($urandom_range(0, 255)));
        if (stored_count < REGION_DEPTH)
        begin
            stored_count++;
            if (code <= 999999)
            begin
                usable = {usable, code};
            end
        end
    endtask

    task automatic put_digits(input int first, input int count, input int value);
        int k;
        int rest;
        rest = value;
        for (k = count - 1; k >= 0; k--)
        begin
            id_buf[first + k] = CH_ZERO + CHAR_W'(rest % 10);
            rest = rest / 10;
        end
    endtask

    // fills the 18 characters and picks the check character by a doubling scan
    task automatic build_number(input int region, input int year, input int month,
                                input int day, input int serial_no);
        int k;
        int r;
        int t;
        put_digits(0, 6, region);
        put_digits(6, 4, year);
        put_digits(10, 2, month);
        put_digits(12, 2, day);
        put_digits(14, 3, serial_no);
        r = 0;
        for (k = 0; k < 17; k++)
        begin
            r = (r * 2 + (id_buf[k] - CH_ZERO)) % 11;
        end
        t = (2 * r) % 11;
        t = (12 - t) % 11;
        id_buf[17] = (t == 10) ? CH_UPPER_X : CH_ZERO + CHAR_W'(t);
    endtask

    task automatic spoil_check();
        if (id_buf[17] == CH_UPPER_X)
        begin
            id_buf[17] = CH_ZERO;
        end
        else if (id_buf[17] == CH_NINE)
        begin
            id_buf[17] = CH_UPPER_X;
        end
        else
        begin
            id_buf[17] = id_buf[17] + 8'd1;
        end
    endtask

    task automatic send_number();
        for (int k = 0; k < 18; k++)
        begin
            send_char(id_buf[k]);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (chk_waiting != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = CFG_DATA_W'(value);
        if (idx == REG_MIN_YEAR)
        begin
            lo_now = value;
        end
        else
        begin
            hi_now = value;
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_window(input int lo, input int hi);
        drain();
        write_reg(REG_MIN_YEAR, lo);
        write_reg(REG_MAX_YEAR, hi);
    endtask

    task automatic reload_table();
        int n;
        int pick;
        send_clear();
        n = $urandom_range(1, 18);
        repeat (n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                send_append($urandom_range(0, 999999));
            end
            else if (pick == 8)
            begin
                send_append($urandom_range(1000000, 20'hFFFFF));
            end
            else
            begin
                send_append($urandom_range(0, 1) ? 999999 : 0);
            end
        end
    endtask

    task automatic random_number();
        int region;
        int year;
        int month;
        int day;
        int pick;
        if (usable.size() > 0 && $urandom_range(0, 9) < 9)
        begin
            region = usable[$urandom_range(0, usable.size() - 1)];
        end
        else
        begin
            region = $urandom_range(0, 999999);
        end
        pick = $urandom_range(0, 9);
        if (pick < 6 && lo_now <= hi_now)
        begin
            year = $urandom_range(lo_now, hi_now);
        end
        else if (pick == 6)
        begin
            year = lo_now;
        end
        else if (pick == 7)
        begin
            year = hi_now;
        end
        else if (pick == 8)
        begin
            year = (lo_now > 0) ? lo_now - 1 : ((hi_now < 9999) ? hi_now + 1 : 0);
        end
        else
        begin
            year = $urandom_range(0, 9999);
        end
        month = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        pick  = $urandom_range(0, 19);
        if (pick < 14)
        begin
            day = $urandom_range(1, 28);
        end
        else if (pick < 17)
        begin
            day = $urandom_range(29, 31);
        end
        else if (pick < 19)
        begin
            month = 2;
            day   = 29;
        end
        else
        begin
            day = $urandom_range(0, 99);
        end
        build_number(region, year, month, day,
                     ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 999));
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            spoil_check();
        end
        else if (pick == 1)
        begin
            id_buf[$urandom_range(0, 17)] = CHAR_W'($urandom_range(0, 255));
        end
        else if (pick == 2)
        begin
            if (id_buf[17] == CH_UPPER_X)
            begin
                id_buf[17] = CH_LOWER_X;
            end
            else
            begin
                id_buf[$urandom_range(0, 16)] = CH_UPPER_X;
            end
        end
        send_number();
    endtask

    task automatic random_phase(input int target);
        int start;
        int pick;
        int k;
        start = beats_sent;
        while (beats_sent - start < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                random_number();
            end
            else if (pick < 84)
            begin
                send_beat(CMD_UNUSED, CODE_W'($urandom_range(0, 20'hFFFFF)),
                          CHAR_W'($urandom_range(0, 255)));
            end
            else if (pick < 89)
            begin
                send_append($urandom_range(0, 20'hFFFFF));
            end
            else if (pick < 94)
            begin
                // a torn number, abandoned by a clear
                k = $urandom_range(1, 17);
                repeat (k)
                begin
                    send_char(CHAR_W'($urandom_range(0, 1) ? 32'(CH_ZERO) + $urandom_range(0, 9)
                                                           : $urandom_range(0, 255)));
                end
                reload_table();
            end
            else
            begin
                reload_table();
            end
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n   = 1'b1;
        idle_on = 1'b1;

        // empty table, then a small table with the code extremes
        build_number(110101, 1990, 5, 17, 123);
        send_number();
        send_clear();
        send_append(110101);
        send_append(0);
        send_append(999999);
        send_append(20'hFFFFF);
        send_number();
        build_number(110101, 1990, 5, 17, 124);
        send_number();

        // leap years and the reset window edges
        build_number(0, 2000, 2, 29, 7);
        send_number();
        build_number(999999, 1900, 2, 29, 8);
        send_number();
        build_number(999999, 1900, 1, 1, 8);
        send_number();
        build_number(110101, 2004, 2, 29, 9);
        send_number();
        build_number(110101, 2001, 2, 29, 9);
        send_number();
        build_number(110101, 2011, 12, 31, 10);
        send_number();
        build_number(110101, 1899, 12, 31, 11);
        send_number();
        build_number(110101, 2012, 1, 1, 11);
        send_number();

        // impossible dates, zero serial, wrong check
        build_number(110101, 1995, 0, 10, 13);
        send_number();
        build_number(110101, 1995, 13, 10, 13);
        send_number();
        build_number(110101, 1995, 6, 0, 13);
        send_number();
        build_number(110101, 1995, 7, 32, 13);
        send_number();
        build_number(110101, 1995, 4, 31, 13);
        send_number();
        build_number(110101, 1995, 6, 15, 0);
        send_number();
        build_number(110101, 1995, 6, 15, 15);
        spoil_check();
        send_number();

        // check character ten, upper and lower case
        serial = 1;
        build_number(110101, 1980, 3, 3, serial);
        while (id_buf[17] != CH_UPPER_X && serial < 999)
        begin
            serial++;
            build_number(110101, 1980, 3, 3, serial);
        end
        send_number();
        id_buf[17] = CH_LOWER_X;
        send_number();

        // bad characters, including X early and the byte extremes
        build_number(110101, 1990, 5, 17, 21);
        id_buf[3] = 8'h41;
        send_number();
        build_number(110101, 1990, 5, 17, 22);
        id_buf[8] = CH_UPPER_X;
        send_number();
        build_number(110101, 1990, 5, 17, 23);
        id_buf[0]  = 8'h00;
        id_buf[17] = 8'hFF;
        send_number();
        build_number(123456, 1990, 5, 17, 25);
        send_number();

        // unused command inside a number, then a clear that abandons one
        build_number(110101, 1988, 8, 8, 27);
        for (int k = 0; k < 5; k++)
        begin
            send_char(id_buf[k]);
        end
        send_beat(CMD_UNUSED, CODE_W'($urandom_range(0, 20'hFFFFF)),
                  CHAR_W'($urandom_range(0, 255)));
        for (int k = 5; k < 18; k++)
        begin
            send_char(id_buf[k]);
        end
        for (int k = 0; k < 7; k++)
        begin
            send_char(id_buf[k]);
        end
        send_clear();
        send_append(110101);
        send_number();

        // full table drops the seventeenth code
        send_clear();
        for (int k = 0; k < REGION_DEPTH; k++)
        begin
            send_append(100000 + k * 1111);
        end
        send_append(654321);
        build_number(654321, 1990, 5, 17, 31);
        send_number();
        build_number(100000 + (REGION_DEPTH - 1) * 1111, 1990, 5, 17, 31);
        send_number();

        random_phase(PHASE_BEATS);
        set_window(0, 9999);
        // receiver holds off while two numbers are offered
        hold_req = 1'b1;
        random_number();
        random_number();
        random_phase(PHASE_BEATS);
        set_window(2000, 1999);
        random_phase(PHASE_BEATS);
        set_window(0, 0);
        random_phase(PHASE_BEATS);
        set_window(9999, 9999);
        random_phase(PHASE_BEATS);
        lo_pick = $urandom_range(0, 9800);
        set_window(lo_pick, lo_pick + $urandom_range(0, 199));
        random_phase(PHASE_BEATS);
        set_window(1900, 2011);
        idle_on = 1'b0;
        random_phase(PHASE_BEATS);
        drain();

        $display("covered %0d beats and %0d verdicts: %0d invalid, %0d male, %0d female",
                 beats_sent, chk_invalid + chk_male + chk_female, chk_invalid, chk_male,
                 chk_female);
        $display("seven year windows incl. full range, reversed and single years; %0d-cycle stall",
                 LONG_HOLD);
        if (chk_errors == 0 && chk_waiting == 0)
        begin
            $display("resident_id_number_checker verification clean");
        end
        else
        begin
            $display("resident_id_number_checker verification failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/ridc_pkg.sv
design/ridc_front.sv
design/ridc_queue.sv
design/ridc_back.sv
design/resident_id_number_checker.sv
design/ridc_checker.sv
bench/ridc_checker.sv
bench/tb_top.sv
